[hw/rtl/emsr_pkg.sv]
`timescale 1ns / 1ps

package emsr_pkg;

   localparam int unsigned EDGES_PER_UNIT_DEF = 100;
   localparam int unsigned COUNT_BITS_DEF     = 16;

   localparam int unsigned DUTY_W     = 8;
   localparam int unsigned OUT_W      = 16;
   localparam int unsigned REQ_W      = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned CSR_ADDR_W = 3;

   localparam logic [DUTY_W-1:0] DUTY_MIN_RST = 8'd0;
   localparam logic [DUTY_W-1:0] DUTY_MAX_RST = 8'd255;

   typedef enum logic [REQ_W-1:0] {
      REQ_RISE_A = 3'd0,
      REQ_RISE_B = 3'd1,
      REQ_KNOB_R = 3'd2,
      REQ_KNOB_L = 3'd3,
      REQ_CLICK  = 3'd4,
      REQ_TICK   = 3'd5
   } req_code_type;

   typedef enum logic {
      CSR_DUTY_MIN = 1'b0,
      CSR_DUTY_MAX = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [DUTY_W-1:0] duty_min;
      logic [DUTY_W-1:0] duty_max;
   } cfg_type;

   typedef struct packed {
      logic [REQ_W-1:0] req_type;
      logic             enc_a;
      logic             enc_b;
   } req_item_type;

   typedef struct packed {
      logic [DUTY_W-1:0]       pwm_duty;
      logic signed [OUT_W-1:0] target_count;
      logic signed [OUT_W-1:0] shown_value;
      logic                    shows_error;
      logic                    stall_flag;
   } rsp_item_type;

endpackage

[hw/rtl/emsr_if.sv]
`timescale 1ns / 1ps

interface emsr_req_if;
   import emsr_pkg::*;

   logic             valid;
   logic             ready;
   logic [REQ_W-1:0] req_type;
   logic             enc_a;
   logic             enc_b;

   modport source (output valid, output req_type, output enc_a, output enc_b, input ready);
   modport sink   (input valid, input req_type, input enc_a, input enc_b, output ready);
endinterface

interface emsr_rsp_if;
   import emsr_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [DUTY_W-1:0]       pwm_duty;
   logic signed [OUT_W-1:0] target_count;
   logic signed [OUT_W-1:0] shown_value;
   logic                    shows_error;
   logic                    stall_flag;

   modport source (output valid, output pwm_duty, output target_count, output shown_value,
                   output shows_error, output stall_flag, input ready);
   modport sink   (input valid, input pwm_duty, input target_count, input shown_value,
                   input shows_error, input stall_flag, output ready);
endinterface

[hw/rtl/emsr_csr.sv]
`timescale 1ns / 1ps

module emsr_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [emsr_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [emsr_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [emsr_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                 pready,
   output emsr_pkg::cfg_type                    cfg
);
   import emsr_pkg::*;

   logic [DUTY_W-1:0] duty_min_ff, duty_min_in;
   logic [DUTY_W-1:0] duty_max_ff, duty_max_in;
   logic              wr_en;
   csr_index_type     sel;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign sel    = csr_index_type'(paddr[2]);

   always_comb begin
      duty_min_in = duty_min_ff;
      duty_max_in = duty_max_ff;
      if (wr_en) begin
         case (sel)
            CSR_DUTY_MIN: duty_min_in = pwdata[DUTY_W-1:0];
            CSR_DUTY_MAX: duty_max_in = pwdata[DUTY_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_min_ff <= DUTY_MIN_RST;
         duty_max_ff <= DUTY_MAX_RST;
      end else begin
         duty_min_ff <= duty_min_in;
         duty_max_ff <= duty_max_in;
      end
   end

   always_comb begin
      case (sel)
         CSR_DUTY_MIN: prdata = CSR_DATA_W'(duty_min_ff);
         CSR_DUTY_MAX: prdata = CSR_DATA_W'(duty_max_ff);
         default:      prdata = '0;
      endcase
   end

   assign cfg.duty_min = duty_min_ff;
   assign cfg.duty_max = duty_max_ff;

endmodule

[hw/rtl/emsr_core.sv]
`timescale 1ns / 1ps

module emsr_core #(
   parameter int unsigned EDGES_PER_UNIT = emsr_pkg::EDGES_PER_UNIT_DEF,
   parameter int unsigned COUNT_BITS     = emsr_pkg::COUNT_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  emsr_pkg::req_item_type req,
   input  emsr_pkg::cfg_type      cfg,
   output emsr_pkg::rsp_item_type result
);
   import emsr_pkg::*;

   localparam int unsigned CB     = COUNT_BITS;
   localparam int unsigned LOG_D  = $clog2(EDGES_PER_UNIT);
   localparam int unsigned SHIFT  = CB + LOG_D;
   localparam int unsigned PROD_W = 2 * CB + 1;
   // ceil(2^SHIFT / EDGES_PER_UNIT) gives an exact quotient for any CB-bit magnitude
   localparam logic [63:0] RECIP_FULL =
      ((64'd1 << SHIFT) + 64'(EDGES_PER_UNIT) - 64'd1) / 64'(EDGES_PER_UNIT);
   localparam logic [CB:0] RECIP = RECIP_FULL[CB:0];

   localparam logic signed [CB-1:0] CNT_MAX = {1'b0, {(CB-1){1'b1}}};
   localparam logic signed [CB-1:0] CNT_MIN = {1'b1, {(CB-1){1'b0}}};
   localparam logic signed [CB-1:0] CNT_ONE = CB'(1);

   logic signed [CB-1:0]    edge_ff, edge_in;
   logic signed [CB-1:0]    latched_ff, latched_in;
   logic [DUTY_W-1:0]       duty_ff, duty_in;
   logic signed [CB-1:0]    target_ff, target_in;
   logic signed [OUT_W-1:0] disp_ff, disp_in;
   logic                    err_ff, err_in;
   logic                    stall;

   logic                    count_dn;
   logic                    target_pos;
   logic [CB-1:0]           mag;
   logic [PROD_W-1:0]       prod;
   logic [CB-1:0]           quo_mag;
   logic signed [CB-1:0]    quot;

   function automatic logic [OUT_W-1:0] to_out(input logic signed [CB-1:0] v);
      logic signed [CB+OUT_W-1:0] w;
      w = (CB+OUT_W)'(v);
      return w[OUT_W-1:0];
   endfunction

   // edge count (the count a tick latches) over the ratio, truncated toward zero
   always_comb begin
      mag     = edge_ff[CB-1] ? CB'(-edge_ff) : CB'(edge_ff);
      prod    = PROD_W'(mag) * PROD_W'(RECIP);
      quo_mag = CB'(prod >> SHIFT);
      quot    = edge_ff[CB-1] ? -$signed(quo_mag) : $signed(quo_mag);
   end

   assign target_pos = !target_ff[CB-1] && (target_ff != '0);
   assign count_dn   = (req.req_type == REQ_RISE_A) ? (req.enc_a == req.enc_b)
                                                    : (req.enc_a != req.enc_b);

   always_comb begin
      edge_in    = edge_ff;
      latched_in = latched_ff;
      duty_in    = duty_ff;
      target_in  = target_ff;
      disp_in    = disp_ff;
      err_in     = err_ff;
      stall      = 1'b0;
      case (req_code_type'(req.req_type))
         REQ_RISE_A, REQ_RISE_B: begin
            if (count_dn) begin
               if (edge_ff != CNT_MIN) edge_in = edge_ff - CNT_ONE;
            end else begin
               if (edge_ff != CNT_MAX) edge_in = edge_ff + CNT_ONE;
            end
         end
         REQ_KNOB_R: begin
            if (target_ff == '0 && duty_ff < cfg.duty_max) begin
               duty_in = duty_ff + 8'd1;
               disp_in = OUT_W'(duty_ff + 8'd1);
               err_in  = 1'b0;
            end
         end
         REQ_KNOB_L: begin
            if (target_ff == '0 && duty_ff > cfg.duty_min) begin
               duty_in = duty_ff - 8'd1;
               disp_in = OUT_W'(duty_ff - 8'd1);
               err_in  = 1'b0;
            end
         end
         REQ_CLICK: begin
            target_in = (duty_ff == '0) ? '0 : latched_ff;
         end
         REQ_TICK: begin
            latched_in = edge_ff;
            if (duty_ff == '0) begin
               disp_in = to_out(edge_ff);
               err_in  = 1'b0;
            end else begin
               edge_in = '0;
               if (target_pos) begin
                  if (edge_ff == '0) begin
                     // stall: motor stopped while regulating
                     duty_in   = '0;
                     target_in = '0;
                     err_in    = 1'b1;
                     stall     = 1'b1;
                  end else begin
                     if (edge_ff > target_ff) begin
                        if (duty_ff > cfg.duty_min) duty_in = duty_ff - 8'd1;
                     end else if (edge_ff < target_ff) begin
                        if (duty_ff < cfg.duty_max) duty_in = duty_ff + 8'd1;
                     end
                     disp_in = to_out(quot);
                     err_in  = 1'b0;
                  end
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_ff    <= '0;
         latched_ff <= '0;
         duty_ff    <= '0;
         target_ff  <= '0;
         disp_ff    <= '0;
         err_ff     <= 1'b0;
      end else if (fire) begin
         edge_ff    <= edge_in;
         latched_ff <= latched_in;
         duty_ff    <= duty_in;
         target_ff  <= target_in;
         disp_ff    <= disp_in;
         err_ff     <= err_in;
      end
   end

   assign result.pwm_duty     = duty_in;
   assign result.target_count = to_out(target_in);
   assign result.shown_value  = disp_in;
   assign result.shows_error  = err_in;
   assign result.stall_flag   = stall;

endmodule

[hw/rtl/encoder_motor_speed_regulator_unit.sv]
`timescale 1ns / 1ps

// channel   direction  transfer when           payload
// req_ch    in         valid && ready          req_type, enc_a, enc_b
// rsp_ch    out        valid && ready          pwm_duty, target_count, shown_value,
//                                              shows_error, stall_flag
// apb       in         psel, penable, pwrite   duty_min at 0x0, duty_max at 0x4
//
// one item per clock while the output is not stalled; a result passes the input
// register, then state update and result register, before it is presented
// synchronous active-high reset clears valid flags and core state, sets duty_max to 255
// the input register keeps taking items while the result register is full but
// being drained; a stalled result holds both stages

module encoder_motor_speed_regulator_unit #(
   parameter int unsigned EDGES_PER_UNIT = emsr_pkg::EDGES_PER_UNIT_DEF,
   parameter int unsigned COUNT_BITS     = emsr_pkg::COUNT_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   emsr_req_if.sink                        req_ch,
   emsr_rsp_if.source                      rsp_ch,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [emsr_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [emsr_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [emsr_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);
   import emsr_pkg::*;

   cfg_type      cfg;
   req_item_type req_ff;
   rsp_item_type rsp_ff;
   rsp_item_type result;
   logic         in_valid_ff, in_valid_in;
   logic         out_valid_ff, out_valid_in;
   logic         advance;
   logic         req_take;

   emsr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   emsr_core #(
      .EDGES_PER_UNIT (EDGES_PER_UNIT),
      .COUNT_BITS     (COUNT_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .req    (req_ff),
      .cfg    (cfg),
      .result (result)
   );

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_take     = req_ch.valid && req_ch.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take)     in_valid_in = 1'b1;
      else if (advance) in_valid_in = 1'b0;

      out_valid_in = out_valid_ff;
      if (advance)           out_valid_in = 1'b1;
      else if (rsp_ch.ready) out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff.req_type <= req_ch.req_type;
         req_ff.enc_a    <= req_ch.enc_a;
         req_ff.enc_b    <= req_ch.enc_b;
      end
      if (advance) rsp_ff <= result;
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.pwm_duty     = rsp_ff.pwm_duty;
   assign rsp_ch.target_count = rsp_ff.target_count;
   assign rsp_ch.shown_value  = rsp_ff.shown_value;
   assign rsp_ch.shows_error  = rsp_ff.shows_error;
   assign rsp_ch.stall_flag   = rsp_ff.stall_flag;

   // a stall result always reports the motor stopped and the error shown
   a_stall_stops: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && rsp_ff.stall_flag |->
         rsp_ff.pwm_duty == '0 && rsp_ff.target_count == '0 && rsp_ff.shows_error)
      else $error("stall result without stopped motor");

   // an item moving to the result stage always leaves a valid result behind
   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("result register empty after advance");

   // both stages full and output blocked: no new transfer may be taken
   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_valid_ff && !rsp_ch.ready |-> !req_ch.ready)
      else $error("request taken while pipeline full");

endmodule

[dv/encoder_motor_speed_regulator_unit_test.sv]
`timescale 1ns / 1ps

module encoder_motor_speed_regulator_unit_test;
   import emsr_pkg::*;

   localparam int COUNT_HI = 2 ** (COUNT_BITS_DEF - 1) - 1;
   localparam int COUNT_LO = -COUNT_HI - 1;
   localparam logic [REQ_W-1:0] REQ_SPARE_6 = 3'd6;
   localparam logic [REQ_W-1:0] REQ_SPARE_7 = 3'd7;

   // running model of the regulator plus the queue of results still owed
   class regulator_scoreboard;
      logic [DUTY_W-1:0]       duty_lo = DUTY_MIN_RST;
      logic [DUTY_W-1:0]       duty_hi = DUTY_MAX_RST;
      logic signed [OUT_W-1:0] edge_count = '0;
      logic signed [OUT_W-1:0] latched_count = '0;
      logic signed [OUT_W-1:0] target = '0;
      logic signed [OUT_W-1:0] display_number = '0;
      logic [DUTY_W-1:0]       duty = '0;
      logic                    display_error = 1'b0;
      rsp_item_type            owed[$];
      int                      errors = 0;

      function void note_event(req_item_type it);
         rsp_item_type      res;
         int                moved;
         logic [DUTY_W-1:0] old_duty;
         logic              stall;
         stall = 1'b0;
         case (it.req_type)
            REQ_RISE_A, REQ_RISE_B: begin
               // rising A counts down on equal levels, rising B on differing ones
               moved = int'(edge_count) +
                       (((it.enc_a == it.enc_b) == (it.req_type == REQ_RISE_A)) ? -1 : 1);
               if (moved > COUNT_HI) moved = COUNT_HI;
               else if (moved < COUNT_LO) moved = COUNT_LO;
               edge_count = moved[OUT_W-1:0];
            end
            REQ_KNOB_R, REQ_KNOB_L: begin
               if (target == 0) begin
                  old_duty = duty;
                  if (it.req_type == REQ_KNOB_R) begin
                     if (duty < duty_hi) duty++;
                  end else if (duty > duty_lo) begin
                     duty--;
                  end
                  if (duty != old_duty) begin
                     display_number = {{(OUT_W - DUTY_W){1'b0}}, duty};
                     display_error  = 1'b0;
                  end
               end
            end
            REQ_CLICK: target = (duty == 0) ? '0 : latched_count;
            REQ_TICK: begin
               latched_count = edge_count;
               if (duty == 0) begin
                  display_number = edge_count;
                  display_error  = 1'b0;
               end else begin
                  edge_count = '0;
                  if (target > 0) begin
                     if (latched_count == 0) begin
                        duty          = '0;
                        target        = '0;
                        display_error = 1'b1;
                        stall         = 1'b1;
                     end else begin
                        if (latched_count > target) begin
                           if (duty > duty_lo) duty--;
                        end else if (latched_count < target) begin
                           if (duty < duty_hi) duty++;
                        end
                        moved = int'(latched_count) / int'(EDGES_PER_UNIT_DEF);
                        display_number = moved[OUT_W-1:0];
                        display_error  = 1'b0;
                     end
                  end
               end
            end
            default: ;
         endcase
         res.pwm_duty     = duty;
         res.target_count = target;
         res.shown_value  = display_number;
         res.shows_error  = display_error;
         res.stall_flag   = stall;
         owed.push_back(res);
      endfunction

      function void check_result(rsp_item_type got);
         rsp_item_type want;
         if (owed.size() == 0) begin
            $error("result transfer with nothing expected (pwm_duty %0d)", got.pwm_duty);
            errors++;
            return;
         end
         want = owed.pop_front();
         if (got.pwm_duty !== want.pwm_duty) begin
            $error("pwm_duty: expected %0d, got %0d", want.pwm_duty, got.pwm_duty);
            errors++;
         end
         if (got.target_count !== want.target_count) begin
            $error("target_count: expected %0d, got %0d", want.target_count, got.target_count);
            errors++;
         end
         if (got.shown_value !== want.shown_value) begin
            $error("shown_value: expected %0d, got %0d", want.shown_value, got.shown_value);
            errors++;
         end
         if (got.shows_error !== want.shows_error) begin
            $error("shows_error: expected %0b, got %0b", want.shows_error, got.shows_error);
            errors++;
         end
         if (got.stall_flag !== want.stall_flag) begin
            $error("stall_flag: expected %0b, got %0b", want.stall_flag, got.stall_flag);
            errors++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   emsr_req_if req_if ();
   emsr_rsp_if rsp_if ();

   encoder_motor_speed_regulator_unit DUT (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_if),
      .rsp_ch  (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   regulator_scoreboard board = new();
   bit                  steady;
   int                  sent_total;

   always #4 clock = ~clock;

   always @(negedge clock) begin
      if (steady) begin
         rsp_if.ready <= 1'b1;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= 20);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            board.check_result(rsp_item_type'{pwm_duty: rsp_if.pwm_duty,
                                              target_count: rsp_if.target_count,
                                              shown_value: rsp_if.shown_value,
                                              shows_error: rsp_if.shows_error,
                                              stall_flag: rsp_if.stall_flag});
         end
         if (req_if.valid && req_if.ready) begin
            board.note_event(req_item_type'{req_type: req_if.req_type,
                                            enc_a: req_if.enc_a,
                                            enc_b: req_if.enc_b});
         end
      end
   end

   function automatic bit rand_bit();
      return 1'($urandom_range(1));
   endfunction

   task automatic send_event(input logic [REQ_W-1:0] code, input bit a, input bit b);
      @(negedge clock);
      while (!steady && $urandom_range(99) < 20) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.req_type <= code;
      req_if.enc_a    <= a;
      req_if.enc_b    <= b;
      do @(posedge clock); while (!req_if.ready);
      sent_total++;
   endtask

   // n encoder edges in one direction, with the odd reversal when jitter is set
   task automatic spin(input int n, input bit down, input bit jitter);
      logic [REQ_W-1:0] code;
      bit               a;
      bit               dir;
      repeat (n) begin
         code = rand_bit() ? REQ_RISE_B : REQ_RISE_A;
         a    = rand_bit();
         dir  = down ^ (jitter && $urandom_range(19) == 0);
         send_event(code, a, a ^ dir ^ (code == REQ_RISE_A));
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (board.owed.size() != 0) @(posedge clock);
   endtask

   task automatic csr_access(input bit wr, input csr_index_type idx,
                             input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= {idx, 2'b00};
      pwdata  <= wdata;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
   endtask

   task automatic set_limits(input logic [DUTY_W-1:0] lo, input logic [DUTY_W-1:0] hi);
      logic [CSR_DATA_W-1:0] rd;
      drain();
      csr_access(1'b1, CSR_DUTY_MIN, CSR_DATA_W'(lo), rd);
      csr_access(1'b1, CSR_DUTY_MAX, CSR_DATA_W'(hi), rd);
      board.duty_lo = lo;
      board.duty_hi = hi;
      csr_access(1'b0, CSR_DUTY_MIN, '0, rd);
      if (rd !== CSR_DATA_W'(lo)) begin
         $error("duty_min: expected %0d, got %0d", lo, rd);
         board.errors++;
      end
      csr_access(1'b0, CSR_DUTY_MAX, '0, rd);
      if (rd !== CSR_DATA_W'(hi)) begin
         $error("duty_max: expected %0d, got %0d", hi, rd);
         board.errors++;
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // mostly regulation runs: set a speed, capture it, then ticks near that speed
   task automatic run_random(input int budget);
      int stop_at;
      int pick;
      int m;
      int k;
      int n;
      bit down;
      stop_at = sent_total + budget;
      while (sent_total < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 15) begin
            send_event(REQ_W'($urandom_range(7)), rand_bit(), rand_bit());
         end else if (pick < 35) begin
            down = rand_bit();
            repeat ($urandom_range(1, 8))
               send_event(down ? REQ_KNOB_L : REQ_KNOB_R, rand_bit(), rand_bit());
         end else begin
            down = ($urandom_range(99) < 15);
            m    = $urandom_range(1, 10);
            k    = $urandom_range(2, 6);
            repeat ($urandom_range(1, 3))
               send_event(REQ_KNOB_R, rand_bit(), rand_bit());
            spin(m, down, 1'b1);
            send_event(REQ_TICK, rand_bit(), rand_bit());
            send_event(REQ_CLICK, rand_bit(), rand_bit());
            repeat (k) begin
               // now and then a tick with no edges at all, i.e. a stalled motor
               if ($urandom_range(9) != 0) begin
                  n = $urandom_range(m + 2, (m > 2) ? m - 2 : 1);
                  spin(n, down, 1'b1);
               end
               send_event(REQ_TICK, rand_bit(), rand_bit());
            end
         end
      end
   endtask

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      req_if.valid   = 1'b0;
      req_if.req_type = REQ_RISE_A;
      req_if.enc_a   = 1'b0;
      req_if.enc_b   = 1'b0;
      rsp_if.ready   = 1'b0;
      steady         = 1'b0;
      sent_total     = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // counting rules for both channels, spare codes
      send_event(REQ_RISE_A, 1'b1, 1'b0);
      send_event(REQ_RISE_A, 1'b1, 1'b1);
      send_event(REQ_RISE_B, 1'b1, 1'b1);
      send_event(REQ_RISE_B, 1'b0, 1'b1);
      send_event(REQ_SPARE_6, 1'b0, 1'b0);
      send_event(REQ_SPARE_7, 1'b1, 1'b1);
      // idle motor: raw count shown, knob at the floor, click clears
      send_event(REQ_TICK, 1'b0, 1'b0);
      send_event(REQ_KNOB_L, 1'b0, 1'b0);
      send_event(REQ_CLICK, 1'b0, 1'b0);
      send_event(REQ_KNOB_R, 1'b1, 1'b0);
      send_event(REQ_KNOB_R, 1'b0, 1'b1);
      send_event(REQ_RISE_A, 1'b1, 1'b0);
      send_event(REQ_RISE_A, 1'b1, 1'b0);
      send_event(REQ_TICK, 1'b0, 1'b0);
      send_event(REQ_CLICK, 1'b0, 1'b0);
      // knob locked out while regulating; step up, step down, then stall
      send_event(REQ_KNOB_R, 1'b0, 1'b0);
      send_event(REQ_RISE_A, 1'b0, 1'b1);
      send_event(REQ_TICK, 1'b1, 1'b1);
      send_event(REQ_RISE_B, 1'b0, 1'b0);
      send_event(REQ_RISE_B, 1'b1, 1'b1);
      send_event(REQ_RISE_B, 1'b0, 1'b0);
      send_event(REQ_TICK, 1'b0, 1'b0);
      send_event(REQ_TICK, 1'b0, 1'b0);
      // negative target
      send_event(REQ_KNOB_R, 1'b0, 1'b0);
      send_event(REQ_RISE_A, 1'b0, 1'b0);
      send_event(REQ_TICK, 1'b0, 1'b0);
      send_event(REQ_CLICK, 1'b1, 1'b1);

      run_random(55);
      set_limits(8'd10, 8'd40);
      steady = 1'b1;
      run_random(55);
      steady = 1'b0;
      set_limits(8'd255, 8'd0);
      run_random(55);
      set_limits(8'd0, 8'd0);
      run_random(55);
      set_limits(8'd3, 8'd6);
      run_random(55);
      set_limits(8'd255, 8'd255);
      run_random(55);
      set_limits(8'd0, 8'd255);
      run_random(55);

      // clear any target, then a one-edge target with counts far above and below it
      send_event(REQ_TICK, 1'b0, 1'b0);
      send_event(REQ_TICK, 1'b0, 1'b0);
      send_event(REQ_CLICK, 1'b0, 1'b0);
      repeat (3) send_event(REQ_KNOB_R, rand_bit(), rand_bit());
      send_event(REQ_TICK, 1'b0, 1'b0);
      spin(1, 1'b0, 1'b0);
      send_event(REQ_TICK, 1'b0, 1'b0);
      send_event(REQ_CLICK, 1'b0, 1'b0);
      spin(105, 1'b0, 1'b0);
      send_event(REQ_TICK, 1'b0, 1'b0);
      spin(105, 1'b1, 1'b0);
      send_event(REQ_TICK, 1'b0, 1'b0);
      spin(5, 1'b0, 1'b0);
      send_event(REQ_TICK, 1'b0, 1'b0);

      drain();
      repeat (10) @(posedge clock);
      if (board.errors == 0) begin
         $display("encoder_motor_speed_regulator_unit_test: done, clean");
      end else begin
         $display("encoder_motor_speed_regulator_unit_test: done, errors");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("encoder_motor_speed_regulator_unit_test: done, errors");
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/emsr_pkg.sv
hw/rtl/emsr_if.sv
hw/rtl/emsr_csr.sv
hw/rtl/emsr_core.sv
hw/rtl/encoder_motor_speed_regulator_unit.sv
dv/encoder_motor_speed_regulator_unit_test.sv
